// ----- hw/rtl/mwsg_pkg.sv -----
// Package for the multi-waveform sample generator.
// Holds the configuration types, register indexes, per-frequency step table and sine table.
// No dependencies.
package mwsg_pkg;

    localparam int LEVEL_W      = 12;
    localparam int INDEX_W      = 7;
    localparam int SINE_ENTRIES = 100;
    localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);

    localparam logic [LEVEL_W-1:0] FULL_MV = 12'd3000;

    typedef enum logic [1:0] {
        CFG_WAVE_SELECT  = 2'd0,
        CFG_FREQ_STEP    = 2'd1,
        CFG_DUTY_PERCENT = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        WAVE_SQUARE   = 2'd0,
        WAVE_SINE     = 2'd1,
        WAVE_RAMP     = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } wave_t;

    typedef struct packed {
        wave_t      wave_select;
        logic [2:0] freq_step;
        logic [6:0] duty_percent;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] phase;
    } stage_t;

    typedef struct packed {
        logic [6:0] period;
        logic [5:0] half;
        logic [2:0] sine_inc;
        logic [7:0] ramp_inc;
        logic [8:0] tri_inc;
    } freq_t;

    function automatic freq_t freq_params(input logic [2:0] step);
        freq_t f;
        unique case (step)
            3'd0, 3'd1: f = '{period: 7'd100, half: 6'd50, sine_inc: 3'd1,
                              ramp_inc: 8'd30, tri_inc: 9'd60};
            3'd2:       f = '{period: 7'd50, half: 6'd25, sine_inc: 3'd2,
                              ramp_inc: 8'd60, tri_inc: 9'd120};
            3'd3:       f = '{period: 7'd33, half: 6'd16, sine_inc: 3'd3,
                              ramp_inc: 8'd90, tri_inc: 9'd180};
            3'd4:       f = '{period: 7'd25, half: 6'd12, sine_inc: 3'd4,
                              ramp_inc: 8'd120, tri_inc: 9'd240};
            default:    f = '{period: 7'd20, half: 6'd10, sine_inc: 3'd5,
                              ramp_inc: 8'd150, tri_inc: 9'd300};
        endcase
        return f;
    endfunction

    localparam logic [LEVEL_W-1:0] SINE_TABLE [SINE_ENTRIES] = '{
        12'd1500, 12'd1594, 12'd1687, 12'd1781, 12'd1873,
        12'd1963, 12'd2052, 12'd2138, 12'd2222, 12'd2303,
        12'd2381, 12'd2456, 12'd2526, 12'd2593, 12'd2655,
        12'd2713, 12'd2766, 12'd2814, 12'd2857, 12'd2894,
        12'd2926, 12'd2952, 12'd2973, 12'd2988, 12'd2997,
        12'd3000, 12'd2997, 12'd2988, 12'd2973, 12'd2952,
        12'd2926, 12'd2894, 12'd2857, 12'd2814, 12'd2766,
        12'd2713, 12'd2655, 12'd2593, 12'd2526, 12'd2456,
        12'd2381, 12'd2303, 12'd2222, 12'd2138, 12'd2052,
        12'd1963, 12'd1873, 12'd1781, 12'd1687, 12'd1594,
        12'd1500, 12'd1405, 12'd1312, 12'd1218, 12'd1126,
        12'd1036, 12'd947,  12'd861,  12'd777,  12'd696,
        12'd618,  12'd543,  12'd473,  12'd406,  12'd344,
        12'd286,  12'd233,  12'd185,  12'd142,  12'd105,
        12'd73,   12'd47,   12'd26,   12'd11,   12'd2,
        12'd0,    12'd2,    12'd11,   12'd26,   12'd47,
        12'd73,   12'd105,  12'd142,  12'd185,  12'd233,
        12'd286,  12'd344,  12'd406,  12'd473,  12'd543,
        12'd618,  12'd696,  12'd777,  12'd861,  12'd947,
        12'd1036, 12'd1126, 12'd1218, 12'd1312, 12'd1405
    };

endpackage

// ----- hw/rtl/mwsg_phase.sv -----
// Sample index counter and input stage of the waveform generator.
// On each input transfer, steps the index when advance is set and wraps it below the period.
// Depends on mwsg_pkg.
module mwsg_phase (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 enable,
    input  logic                 advance,
    input  logic [2:0]           freq_step,
    output mwsg_pkg::stage_t     stage
);

    mwsg_pkg::freq_t                 freq;
    logic [mwsg_pkg::INDEX_W-1:0]    phase_count_reg;
    logic [mwsg_pkg::INDEX_W-1:0]    phase_count_next;
    logic [mwsg_pkg::INDEX_W-1:0]    stepped;
    logic                            valid_reg;
    logic                            valid_next;

    always_comb
    begin
        freq    = mwsg_pkg::freq_params(freq_step);
        stepped = advance ? phase_count_reg + 7'd1 : phase_count_reg;
        if (!accept)
        begin
            phase_count_next = phase_count_reg;
        end
        else if (stepped >= freq.period)
        begin
            phase_count_next = '0;
        end
        else
        begin
            phase_count_next = stepped;
        end
        valid_next = enable ? accept : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_count_reg <= '0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            phase_count_reg <= phase_count_next;
            valid_reg       <= valid_next;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.phase = phase_count_reg;

    a_phase_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> phase_count_reg < $past(freq.period))
        else $error("sample index not wrapped below period");

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !advance && phase_count_reg < freq.period) |=> $stable(phase_count_reg))
        else $error("sample index moved without advance");

endmodule

// ----- hw/rtl/mwsg_level.sv -----
// Level computation of the waveform generator.
// Maps the sample index and configuration to an output level in mV.
// Depends on mwsg_pkg.
module mwsg_level (
    input  mwsg_pkg::cfg_t                  cfg,
    input  logic [mwsg_pkg::INDEX_W-1:0]    phase,
    output logic [mwsg_pkg::LEVEL_W-1:0]    level_mv
);

    mwsg_pkg::freq_t                  freq;
    logic [13:0]                      square_lhs;
    logic [13:0]                      square_rhs;
    logic [9:0]                       sine_idx;
    logic [mwsg_pkg::SINE_IDX_W-1:0]  sine_addr;
    logic [15:0]                      ramp_level;
    logic [15:0]                      tri_rise;
    logic [15:0]                      tri_drop;
    logic [15:0]                      raw;

    always_comb
    begin
        freq       = mwsg_pkg::freq_params(cfg.freq_step);
        square_lhs = 14'(phase) * 14'd100;
        square_rhs = 14'(freq.period) * 14'(cfg.duty_percent);
        sine_idx   = 10'(freq.sine_inc) * 10'(phase);
        if (sine_idx >= 10'(mwsg_pkg::SINE_ENTRIES))
        begin
            sine_addr = mwsg_pkg::SINE_IDX_W'(mwsg_pkg::SINE_ENTRIES - 1);
        end
        else
        begin
            sine_addr = sine_idx[mwsg_pkg::SINE_IDX_W-1:0];
        end
        ramp_level = 16'(freq.ramp_inc) * 16'(phase);
        tri_rise   = 16'(freq.tri_inc) * 16'(phase);
        tri_drop   = 16'(freq.tri_inc) * 16'(phase - 7'(freq.half));

        unique case (cfg.wave_select)
            mwsg_pkg::WAVE_SQUARE:
            begin
                raw = (square_lhs < square_rhs) ? 16'(mwsg_pkg::FULL_MV) : 16'd0;
            end
            mwsg_pkg::WAVE_SINE:
            begin
                raw = 16'(mwsg_pkg::SINE_TABLE[sine_addr]);
            end
            mwsg_pkg::WAVE_RAMP:
            begin
                raw = ramp_level;
            end
            mwsg_pkg::WAVE_TRIANGLE:
            begin
                if (phase < 7'(freq.half))
                begin
                    raw = tri_rise;
                end
                else if (tri_drop >= 16'(mwsg_pkg::FULL_MV))
                begin
                    raw = 16'd0;
                end
                else
                begin
                    raw = 16'(mwsg_pkg::FULL_MV) - tri_drop;
                end
            end
            default:
            begin
                raw = 16'd0;
            end
        endcase

        if (raw > 16'(mwsg_pkg::FULL_MV))
        begin
            level_mv = mwsg_pkg::FULL_MV;
        end
        else
        begin
            level_mv = raw[mwsg_pkg::LEVEL_W-1:0];
        end
    end

endmodule

// ----- hw/rtl/multi_waveform_sample_generator_core.sv -----
// Top level of the multi-waveform sample generator.
// Holds the configuration registers and result register; uses mwsg_phase, mwsg_level, mwsg_pkg.
//
// Usage:
//   Input channel: in_valid / in_stall with field advance. Each transfer steps the sample
//   index when advance is 1, wraps it to 0 at the samples-per-period count, and yields one
//   result.
//   Output channel: out_valid / out_stall with level_mv (0..3000 mV) and sample_index.
//   Configuration channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is the
//   waveform, 1 the frequency step, 2 the square duty percent. cfg_ready is always high.
//   Write configuration only while no result is pending.
//   Path: input transfer to result through the index register, then the result register.
//   Throughput: one item per cycle while no result waits under out_stall.
//   Reset: index clears to 0, sine waveform, frequency step 1, duty 50, no result pending.
//   Stall: while a result waits under out_stall, in_stall is raised and both stages hold.
module multi_waveform_sample_generator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            advance,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mwsg_pkg::LEVEL_W-1:0]    level_mv,
    output logic [mwsg_pkg::INDEX_W-1:0]    sample_index,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [6:0]                      cfg_data
);

    mwsg_pkg::cfg_t                   cfg_reg;
    mwsg_pkg::cfg_t                   cfg_next;
    mwsg_pkg::stage_t                 stage;
    logic                             enable;
    logic                             accept;
    logic [mwsg_pkg::LEVEL_W-1:0]     level_calc;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [mwsg_pkg::LEVEL_W-1:0]     level_reg;
    logic [mwsg_pkg::LEVEL_W-1:0]     level_next;
    logic [mwsg_pkg::INDEX_W-1:0]     index_reg;
    logic [mwsg_pkg::INDEX_W-1:0]     index_next;

    assign enable    = !out_valid_reg || !out_stall;
    assign in_stall  = !enable;
    assign accept    = in_valid && enable;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (mwsg_pkg::cfg_index_t'(cfg_index))
                mwsg_pkg::CFG_WAVE_SELECT:  cfg_next.wave_select  = mwsg_pkg::wave_t'(cfg_data[1:0]);
                mwsg_pkg::CFG_FREQ_STEP:    cfg_next.freq_step    = cfg_data[2:0];
                mwsg_pkg::CFG_DUTY_PERCENT: cfg_next.duty_percent = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wave_select  <= mwsg_pkg::WAVE_SINE;
            cfg_reg.freq_step    <= 3'd1;
            cfg_reg.duty_percent <= 7'd50;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mwsg_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .enable    (enable),
        .advance   (advance),
        .freq_step (cfg_reg.freq_step),
        .stage     (stage)
    );

    mwsg_level u_level (
        .cfg      (cfg_reg),
        .phase    (stage.phase),
        .level_mv (level_calc)
    );

    always_comb
    begin
        out_valid_next = enable ? stage.valid : out_valid_reg;
        level_next     = (enable && stage.valid) ? level_calc : level_reg;
        index_next     = (enable && stage.valid) ? stage.phase : index_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
        index_reg <= index_next;
    end

    assign out_valid    = out_valid_reg;
    assign level_mv     = level_reg;
    assign sample_index = index_reg;

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> level_mv <= mwsg_pkg::FULL_MV)
        else $error("level above full scale");

    a_square_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cfg_reg.wave_select == mwsg_pkg::WAVE_SQUARE)
            |-> (level_mv == 12'd0 || level_mv == mwsg_pkg::FULL_MV))
        else $error("square level not at a rail");

    a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (stage.valid && enable) |=> out_valid)
        else $error("result lost between stages");

endmodule

// ----- bench/multi_waveform_sample_generator_core_tb.sv -----
// Self-checking testbench for multi_waveform_sample_generator_core.
// Directed table plus randomized phases under varied idle and stall, checked by
// a local level predictor; depends on mwsg_pkg and the core RTL only.
module multi_waveform_sample_generator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TOP_MV         = 3000;
    localparam int unsigned MID_LEVEL      = 1500;
    localparam int unsigned SAMPLE_RATE_HZ = 10000;
    localparam int unsigned HZ_PER_FSTEP   = 100;
    localparam bit [63:0]   HALF_PI_Q62    = 64'h6487ED5110B4611A;
    localparam bit [63:0]   LOW_WORD       = 64'hFFFF_FFFF;
    localparam int unsigned EXACT_TWELFTHS [12] = '{
        1500, 2250, 2799, 3000, 2799, 2250, 1500, 750, 200, 0, 200, 750
    };

    localparam int SRC_IDLE_PCT [4]   = '{0, 64, 0, 11};
    localparam int SINK_STALL_PCT [4] = '{0, 0, 64, 11};
    localparam int FREQ_CORNER [4]    = '{0, 7, 1, 5};
    localparam int DUTY_CORNER [4]    = '{0, 127, 10, 90};
    localparam int RANDOM_PHASES      = 32;

    localparam logic [6:0] SQUARE_CODE   = 7'(mwsg_pkg::WAVE_SQUARE);
    localparam logic [6:0] SINE_CODE     = 7'(mwsg_pkg::WAVE_SINE);
    localparam logic [6:0] RAMP_CODE     = 7'(mwsg_pkg::WAVE_RAMP);
    localparam logic [6:0] TRIANGLE_CODE = 7'(mwsg_pkg::WAVE_TRIANGLE);

    typedef struct packed {
        logic [mwsg_pkg::LEVEL_W-1:0] mv;
        logic [mwsg_pkg::INDEX_W-1:0] pos;
    } sample_t;

    typedef struct packed {
        logic                         is_write;
        mwsg_pkg::cfg_index_t         sel;
        logic [6:0]                   data;
        logic [4:0]                   count;
        logic                         adv;
        logic                         typed;
        logic [mwsg_pkg::LEVEL_W-1:0] mv;
        logic [mwsg_pkg::INDEX_W-1:0] pos;
    } plan_row_t;

    localparam int DIRECTED_ROWS = 24;
    localparam plan_row_t DIRECTED_PLAN [DIRECTED_ROWS] = '{
        '{1'b0, mwsg_pkg::CFG_UNUSED,       7'd0,          5'd1,  1'b0, 1'b1, 12'd1500, 7'd0},
        '{1'b0, mwsg_pkg::CFG_UNUSED,       7'd0,          5'd1,  1'b1, 1'b1, 12'd1594, 7'd1},
        '{1'b1, mwsg_pkg::CFG_WAVE_SELECT,  SQUARE_CODE,   5'd0,  1'b0, 1'b0, 12'd0,    7'd0},
        '{1'b1, mwsg_pkg::CFG_DUTY_PERCENT, 7'd0,          5'd0,  1'b0, 1'b0, 12'd0,    7'd0},
        '{1'b0, mwsg_pkg::CFG_UNUSED,       7'd0,          5'd1,  1'b0, 1'b1, 12'd0,    7'd1},
        '{1'b1, mwsg_pkg::CFG_DUTY_PERCENT, 7'd127,        5'd0,  1'b0, 1'b0, 12'd0,    7'd0},
        '{1'b0, mwsg_pkg::CFG_UNUSED,       7'd0,          5'd1,  1'b1, 1'b1, 12'd3000, 7'd2},
        '{1'b1, mwsg_pkg::CFG_DUTY_PERCENT, 7'd10,         5'd0,  1'b0, 1'b0, 12'd0,    7'd0},
        '{1'b1, mwsg_pkg::CFG_FREQ_STEP,    7'd0,          5'd0,  1'b0, 1'b0, 12'd0,    7'd0},
        '{1'b0, mwsg_pkg::CFG_UNUSED,       7'd0,          5'd7,  1'b1, 1'b0, 12'd0,    7'd0},
        '{1'b0, mwsg_pkg::CFG_UNUSED,       7'd0,          5'd1,  1'b1, 1'b1, 12'd0,    7'd10},
        '{1'b1, mwsg_pkg::CFG_WAVE_SELECT,  TRIANGLE_CODE, 5'd0,  1'b0, 1'b0, 12'd0,    7'd0},
        '{1'b0, mwsg_pkg::CFG_UNUSED,       7'd0,          5'd10, 1'b1, 1'b0, 12'd0,    7'd0},
        '{1'b1, mwsg_pkg::CFG_FREQ_STEP,    7'd7,          5'd0,  1'b0, 1'b0, 12'd0,    7'd0},
        '{1'b0, mwsg_pkg::CFG_UNUSED,       7'd0,          5'd1,  1'b0, 1'b1, 12'd0,    7'd0},
        '{1'b1, mwsg_pkg::CFG_UNUSED,       7'd127,        5'd0,  1'b0, 1'b0, 12'd0,    7'd0},
        '{1'b1, mwsg_pkg::CFG_WAVE_SELECT,  RAMP_CODE,     5'd0,  1'b0, 1'b0, 12'd0,    7'd0},
        '{1'b0, mwsg_pkg::CFG_UNUSED,       7'd0,          5'd1,  1'b1, 1'b1, 12'd150,  7'd1},
        '{1'b1, mwsg_pkg::CFG_WAVE_SELECT,  SINE_CODE,     5'd0,  1'b0, 1'b0, 12'd0,    7'd0},
        '{1'b0, mwsg_pkg::CFG_UNUSED,       7'd0,          5'd1,  1'b1, 1'b0, 12'd0,    7'd0},
        '{1'b1, mwsg_pkg::CFG_FREQ_STEP,    7'd6,          5'd0,  1'b0, 1'b0, 12'd0,    7'd0},
        '{1'b1, mwsg_pkg::CFG_DUTY_PERCENT, 7'd90,         5'd0,  1'b0, 1'b0, 12'd0,    7'd0},
        '{1'b1, mwsg_pkg::CFG_WAVE_SELECT,  SQUARE_CODE,   5'd0,  1'b0, 1'b0, 12'd0,    7'd0},
        '{1'b0, mwsg_pkg::CFG_UNUSED,       7'd0,          5'd2,  1'b1, 1'b0, 12'd0,    7'd0}
    };

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic                         advance;
    logic                         out_valid;
    logic                         out_stall;
    logic [mwsg_pkg::LEVEL_W-1:0] level_mv;
    logic [mwsg_pkg::INDEX_W-1:0] sample_index;
    logic                         cfg_valid;
    logic                         cfg_ready;
    mwsg_pkg::cfg_index_t         cfg_index;
    logic [6:0]                   cfg_data;

    mwsg_pkg::wave_t              gen_wave;
    logic [2:0]                   gen_freq;
    logic [6:0]                   gen_duty;
    logic [mwsg_pkg::INDEX_W-1:0] gen_phase;
    logic [mwsg_pkg::LEVEL_W-1:0] sine_mv [mwsg_pkg::SINE_ENTRIES];

    sample_t            pending_samples [$];
    int                 mismatch_count = 0;
    int                 src_idle_pct   = 0;
    int                 sink_stall_pct = 0;

    multi_waveform_sample_generator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .advance      (advance),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .level_mv     (level_mv),
        .sample_index (sample_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic bit [63:0] q62_mul(input bit [63:0] a, input bit [63:0] b);
        bit [63:0] a0, a1, b0, b1, p00, p01, p10, p11, mid, hi, lo;
        a0  = a & LOW_WORD;
        a1  = a >> 32;
        b0  = b & LOW_WORD;
        b1  = b >> 32;
        p00 = a0 * b0;
        p01 = a0 * b1;
        p10 = a1 * b0;
        p11 = a1 * b1;
        mid = (p00 >> 32) + (p01 & LOW_WORD) + (p10 & LOW_WORD);
        hi  = p11 + (p01 >> 32) + (p10 >> 32) + (mid >> 32);
        lo  = (mid << 32) | (p00 & LOW_WORD);
        return (hi << 2) | (lo >> 62);
    endfunction

    function automatic bit [63:0] q62_sine(input bit [63:0] x);
        bit [63:0] x2, term, acc;
        x2   = q62_mul(x, x);
        term = x;
        acc  = x;
        for (int k = 1; k <= 12; k++)
        begin
            term = q62_mul(term, x2) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return acc;
    endfunction

    function automatic logic [mwsg_pkg::LEVEL_W-1:0] sine_level(input int unsigned d);
        bit [63:0] n, q, x, s, v, ip, fr;
        bit        neg;
        n = mwsg_pkg::SINE_ENTRIES;
        if ((12 * d) % mwsg_pkg::SINE_ENTRIES == 0)
            return mwsg_pkg::LEVEL_W'(
                EXACT_TWELFTHS[((12 * d) / mwsg_pkg::SINE_ENTRIES) % 12]);
        q   = 4 * d;
        neg = q >= 2 * n;
        if (neg)
            q = q - 2 * n;
        if (q > n)
            q = 2 * n - q;
        x  = (HALF_PI_Q62 / n) * q + ((HALF_PI_Q62 % n) * q) / n;
        s  = q62_sine(x);
        v  = (s >> 20) * MID_LEVEL;
        ip = v >> 42;
        fr = v & ((64'd1 << 42) - 1);
        if (ip > MID_LEVEL)
            ip = MID_LEVEL;
        if (neg)
            return mwsg_pkg::LEVEL_W'(
                MID_LEVEL - ip - ((fr != 0 && ip < MID_LEVEL) ? 1 : 0));
        return mwsg_pkg::LEVEL_W'(MID_LEVEL + ip);
    endfunction

    function automatic sample_t step_generator(input bit adv);
        int unsigned fstep, period, half, inc, drop, lvl, sidx, ph;
        sample_t     res;
        fstep = gen_freq;
        if (fstep < 1)
            fstep = 1;
        if (fstep > 5)
            fstep = 5;
        period = SAMPLE_RATE_HZ / (HZ_PER_FSTEP * fstep);
        if (adv)
            gen_phase = gen_phase + 7'd1;
        if (gen_phase >= period)
            gen_phase = '0;
        ph = gen_phase;
        case (gen_wave)
            mwsg_pkg::WAVE_SQUARE:
                lvl = (ph * 100 < period * gen_duty) ? TOP_MV : 0;
            mwsg_pkg::WAVE_SINE:
            begin
                sidx = (mwsg_pkg::SINE_ENTRIES / period) * ph;
                if (sidx >= mwsg_pkg::SINE_ENTRIES)
                    sidx = mwsg_pkg::SINE_ENTRIES - 1;
                lvl = sine_mv[sidx];
            end
            mwsg_pkg::WAVE_RAMP:
                lvl = (TOP_MV / period) * ph;
            default:
            begin
                half = period / 2;
                inc  = (TOP_MV / period) * 2;
                if (ph < half)
                    lvl = inc * ph;
                else
                begin
                    drop = inc * (ph - half);
                    lvl  = (drop >= TOP_MV) ? 0 : TOP_MV - drop;
                end
            end
        endcase
        if (lvl > TOP_MV)
            lvl = TOP_MV;
        res.mv  = lvl[mwsg_pkg::LEVEL_W-1:0];
        res.pos = gen_phase;
        return res;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic push_sample(input bit adv, input bit typed, input sample_t want);
        sample_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        advance  <= adv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = step_generator(adv);
        pending_samples.push_back(typed ? want : predicted);
    endtask

    task automatic write_reg(input mwsg_pkg::cfg_index_t sel, input logic [6:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (sel)
            mwsg_pkg::CFG_WAVE_SELECT:  gen_wave = mwsg_pkg::wave_t'(value[1:0]);
            mwsg_pkg::CFG_FREQ_STEP:    gen_freq = value[2:0];
            mwsg_pkg::CFG_DUTY_PERCENT: gen_duty = value;
            default:                    ;
        endcase
    endtask

    task automatic wait_idle;
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (pending_samples.size() != 0 && guard < 4000)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < sink_stall_pct);

    always @(posedge clk)
    begin : watch_results
        sample_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_samples.size() == 0)
                note_mismatch($sformatf("unexpected transfer level %0d index %0d",
                                        level_mv, sample_index));
            else
            begin
                want = pending_samples.pop_front();
                if (level_mv !== want.mv)
                    note_mismatch($sformatf("level_mv %0d, want %0d (index %0d)",
                                            level_mv, want.mv, want.pos));
                if (sample_index !== want.pos)
                    note_mismatch($sformatf("sample_index %0d, want %0d",
                                            sample_index, want.pos));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int n;
        logic [6:0] duty;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        advance   = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = mwsg_pkg::CFG_WAVE_SELECT;
        cfg_data  = '0;
        gen_wave  = mwsg_pkg::WAVE_SINE;
        gen_freq  = 3'd1;
        gen_duty  = 7'd50;
        gen_phase = '0;
        for (int d = 0; d < mwsg_pkg::SINE_ENTRIES; d++)
            sine_mv[d] = sine_level(d);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (DIRECTED_PLAN[r].is_write)
            begin
                wait_idle();
                write_reg(DIRECTED_PLAN[r].sel, DIRECTED_PLAN[r].data);
            end
            else
            begin
                cfg_valid <= 1'b0;
                repeat (DIRECTED_PLAN[r].count)
                    push_sample(DIRECTED_PLAN[r].adv, DIRECTED_PLAN[r].typed,
                                '{mv: DIRECTED_PLAN[r].mv, pos: DIRECTED_PLAN[r].pos});
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            src_idle_pct   = SRC_IDLE_PCT[ph % 4];
            sink_stall_pct = SINK_STALL_PCT[ph % 4];
            write_reg(mwsg_pkg::CFG_WAVE_SELECT,
                      7'(($urandom_range(0, 31) << 2) | ((ph + ph / 4) % 4)));
            if (ph < 4)
                write_reg(mwsg_pkg::CFG_FREQ_STEP, 7'(FREQ_CORNER[ph]));
            else
                write_reg(mwsg_pkg::CFG_FREQ_STEP, 7'($urandom_range(0, 127)));
            if (ph < 4)
                duty = 7'(DUTY_CORNER[ph]);
            else if ($urandom_range(0, 3) == 0)
                duty = 7'($urandom_range(0, 127));
            else
                duty = 7'(10 * $urandom_range(1, 9));
            write_reg(mwsg_pkg::CFG_DUTY_PERCENT, duty);
            if ($urandom_range(0, 3) == 0)
                write_reg(mwsg_pkg::CFG_UNUSED, 7'($urandom_range(0, 127)));
            cfg_valid <= 1'b0;
            n = $urandom_range(30, 73);
            repeat (n)
                push_sample($urandom_range(0, 99) < 85, 1'b0, '0);
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (pending_samples.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_samples.size()));
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/mwsg_pkg.sv
hw/rtl/mwsg_phase.sv
hw/rtl/mwsg_level.sv
hw/rtl/multi_waveform_sample_generator_core.sv
bench/multi_waveform_sample_generator_core_tb.sv
